// ===== sv/gsa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and constants of the generational slot allocator
// Opcodes, status codes, and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package gsa_pkg;

	localparam int SLOT_COUNT_DEF = 1024;
	localparam int GEN_BITS_DEF   = 16;
	localparam int FRAME_W        = 32;
	localparam int DELAY_W        = 16;
	localparam int OPCODE_W       = 2;
	localparam int STATUS_W       = 2;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(3);

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_DESTROY = 2'd1,
		OP_RELEASE = 2'd2,
		OP_CHECK   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_STALE = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Which index and generation the result item carries.
	typedef enum logic [2:0] {
		EMIT_NEW     = 3'd0,
		EMIT_REUSE   = 3'd1,
		EMIT_FULL    = 3'd2,
		EMIT_RANGE   = 3'd3,
		EMIT_SLOT    = 3'd4,
		EMIT_RETIRE  = 3'd5,
		EMIT_RELEASE = 3'd6
	} emit_kind_t;

	typedef struct packed {
		logic       latch;
		logic       pop_free;
		logic       new_slot;
		logic       revive;
		logic       retire;
		logic       drain;
		logic       emit;
		status_t    status;
		emit_kind_t kind;
	} cmd_t;

	typedef struct packed {
		logic free_empty;
		logic table_full;
		logic out_of_range;
		logic slot_live;
		logic gen_match;
		logic drain_ok;
	} stat_t;

endpackage

`default_nettype wire

// ===== sv/gsa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/gsa_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_ctrl: controller of the slot allocator
// Sequences each item through its memory reads and writes and issues
// the result strobe.
// ----------------------------------------------------------------------------
module gsa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [gsa_pkg::OPCODE_W-1:0]  opcode,
	input  wire gsa_pkg::stat_t                stat,
	output gsa_pkg::cmd_t                      cmd,
	output logic                               busy,
	output logic                               done
);

	import gsa_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_ALLOC    = 6'b000010,
		S_ALLOC_RD = 6'b000100,
		S_DESTROY  = 6'b001000,
		S_CHECK    = 6'b010000,
		S_RELEASE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.status = ST_OK;
		cmd.kind   = EMIT_RELEASE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					unique case (opcode_t'(opcode))
						OP_ALLOC:   state_d = S_ALLOC;
						OP_DESTROY: state_d = S_DESTROY;
						OP_RELEASE: state_d = S_RELEASE;
						OP_CHECK:   state_d = S_CHECK;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_ALLOC: begin
				if (!stat.free_empty) begin
					cmd.pop_free = 1'b1;
					state_d = S_ALLOC_RD;
				end else if (!stat.table_full) begin
					cmd.new_slot = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = EMIT_NEW;
					state_d = S_IDLE;
				end else begin
					cmd.emit = 1'b1;
					cmd.status = ST_FULL;
					cmd.kind = EMIT_FULL;
					state_d = S_IDLE;
				end
			end
			S_ALLOC_RD: begin
				cmd.revive = 1'b1;
				cmd.emit = 1'b1;
				cmd.kind = EMIT_REUSE;
				state_d = S_IDLE;
			end
			S_DESTROY: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
				if (stat.out_of_range) begin
					cmd.status = ST_RANGE;
					cmd.kind = EMIT_RANGE;
				end else if (!stat.slot_live) begin
					cmd.status = ST_STALE;
					cmd.kind = EMIT_SLOT;
				end else begin
					cmd.retire = 1'b1;
					cmd.kind = EMIT_RETIRE;
				end
			end
			S_CHECK: begin
				cmd.emit = 1'b1;
				state_d = S_IDLE;
				if (stat.out_of_range) begin
					cmd.status = ST_RANGE;
					cmd.kind = EMIT_RANGE;
				end else begin
					cmd.status = (stat.slot_live && stat.gen_match) ? ST_OK : ST_STALE;
					cmd.kind = EMIT_SLOT;
				end
			end
			S_RELEASE: begin
				if (stat.drain_ok) begin
					cmd.drain = 1'b1;
				end else begin
					cmd.emit = 1'b1;
					cmd.kind = EMIT_RELEASE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ===== sv/gsa_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gsa_dp: datapath of the slot allocator
// Slot table, free stack and retired queue memories with their pointers,
// counters and result registers.
// ----------------------------------------------------------------------------
module gsa_dp #(
	parameter int SLOT_COUNT      = gsa_pkg::SLOT_COUNT_DEF,
	parameter int GENERATION_BITS = gsa_pkg::GEN_BITS_DEF,
	localparam int IDX_W = $clog2(SLOT_COUNT),
	localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gsa_pkg::DELAY_W-1:0]   cfg_wdata,
	input  wire logic [IDX_W-1:0]              slot_index,
	input  wire logic [GENERATION_BITS-1:0]    handle_generation,
	input  wire logic [gsa_pkg::FRAME_W-1:0]   frame,
	input  wire gsa_pkg::cmd_t                 cmd,
	output gsa_pkg::stat_t                     stat,
	output logic [gsa_pkg::STATUS_W-1:0]       status,
	output logic [IDX_W-1:0]                   result_index,
	output logic [GENERATION_BITS-1:0]         result_generation,
	output logic [CNT_W-1:0]                   live_count,
	output logic [CNT_W-1:0]                   used_extent,
	output logic [CNT_W-1:0]                   released_count
);

	import gsa_pkg::*;

	localparam int GEN_W = GENERATION_BITS;
	localparam int RET_W = IDX_W + FRAME_W;

	// Control state.
	logic [DELAY_W-1:0] delay_q;
	logic [CNT_W-1:0]   extent_q;
	logic [CNT_W-1:0]   live_q;
	logic [CNT_W-1:0]   depth_q;
	logic [IDX_W-1:0]   head_q;
	logic [CNT_W-1:0]   rcount_q;
	logic [CNT_W-1:0]   rel_n_q;

	// Item payload.
	logic [IDX_W-1:0]   idx_q;
	logic [GEN_W-1:0]   hgen_q;
	logic [FRAME_W-1:0] frame_q;
	logic [IDX_W-1:0]   slot_q;
	status_t            status_q;
	logic [IDX_W-1:0]   res_idx_q;
	logic [GEN_W-1:0]   res_gen_q;

	// Slot table: live bit on top of the generation.
	logic             slot_we;
	logic [IDX_W-1:0] slot_waddr;
	logic [GEN_W:0]   slot_wdata;
	logic [IDX_W-1:0] slot_raddr;
	logic [GEN_W:0]   slot_rdata;
	logic             ram_live;
	logic [GEN_W-1:0] ram_gen;
	logic [GEN_W-1:0] gen_bump;

	// Free stack.
	logic [CNT_W-1:0] depth_dec;
	logic [IDX_W-1:0] free_raddr;
	logic [IDX_W-1:0] free_rdata;

	// Retired queue.
	logic [IDX_W:0]     head_sum;
	logic [IDX_W-1:0]   head_inc;
	logic [IDX_W+1:0]   tail_sum;
	logic [IDX_W-1:0]   tail;
	logic [IDX_W-1:0]   ret_raddr;
	logic [RET_W-1:0]   ret_rdata;
	logic [RET_W-1:0]   ret_wdata;
	logic               ret_we;
	logic [IDX_W-1:0]   ret_slot;
	logic [FRAME_W-1:0] ret_frame;
	logic [FRAME_W:0]   due_sum;
	logic [FRAME_W-1:0] due;

	assign ram_live = slot_rdata[GEN_W];
	assign ram_gen  = slot_rdata[GEN_W-1:0];
	assign gen_bump = ((ram_gen + GEN_W'(1)) == '0) ? GEN_W'(1) : (ram_gen + GEN_W'(1));

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = {1'b0, gen_bump};
		if (cmd.new_slot) begin
			slot_we    = 1'b1;
			slot_waddr = extent_q[IDX_W-1:0];
			slot_wdata = {1'b1, GEN_W'(1)};
		end else if (cmd.revive) begin
			slot_we    = 1'b1;
			slot_waddr = slot_q;
			slot_wdata = {1'b1, ram_gen};
		end else if (cmd.retire) begin
			slot_we    = 1'b1;
		end
	end

	// The input port addresses the table while idle so that destroy and
	// check find the slot word ready in the cycle after the accept.
	assign slot_raddr = cmd.pop_free ? free_rdata : slot_index;

	gsa_ram #(
		.WIDTH (GEN_W + 1),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	assign depth_dec  = depth_q - CNT_W'(1);
	assign free_raddr = depth_dec[IDX_W-1:0];

	gsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (SLOT_COUNT)
	) u_free_ram (
		.clk   (clk),
		.we    (cmd.drain),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (ret_slot),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	assign head_sum = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(1);
	assign head_inc = (head_sum == (IDX_W + 1)'(SLOT_COUNT)) ? '0 : head_sum[IDX_W-1:0];

	always_comb begin
		tail_sum = (IDX_W + 2)'(head_q) + (IDX_W + 2)'(rcount_q);
		if (tail_sum >= (IDX_W + 2)'(SLOT_COUNT)) begin
			tail_sum = tail_sum - (IDX_W + 2)'(SLOT_COUNT);
		end
		tail = tail_sum[IDX_W-1:0];
	end

	assign due_sum   = {1'b0, frame_q} + (FRAME_W + 1)'(delay_q);
	assign due       = due_sum[FRAME_W] ? '1 : due_sum[FRAME_W-1:0];
	assign ret_we    = cmd.retire && (rcount_q < CNT_W'(SLOT_COUNT));
	assign ret_wdata = {idx_q, due};
	assign ret_raddr = cmd.drain ? head_inc : head_q;
	assign ret_slot  = ret_rdata[FRAME_W +: IDX_W];
	assign ret_frame = ret_rdata[FRAME_W-1:0];

	gsa_ram #(
		.WIDTH (RET_W),
		.DEPTH (SLOT_COUNT)
	) u_ret_ram (
		.clk   (clk),
		.we    (ret_we),
		.waddr (tail),
		.wdata (ret_wdata),
		.raddr (ret_raddr),
		.rdata (ret_rdata)
	);

	always_comb begin
		stat.free_empty   = (depth_q == '0);
		stat.table_full   = (extent_q == CNT_W'(SLOT_COUNT));
		stat.out_of_range = (CNT_W'(idx_q) >= extent_q);
		stat.slot_live    = ram_live;
		stat.gen_match    = (ram_gen == hgen_q);
		stat.drain_ok     = (rcount_q != '0) && (ret_frame <= frame_q)
			&& (depth_q < CNT_W'(SLOT_COUNT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RESET;
			extent_q <= '0;
			live_q   <= '0;
			depth_q  <= '0;
			head_q   <= '0;
			rcount_q <= '0;
			rel_n_q  <= '0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			if (cmd.latch) begin
				rel_n_q <= '0;
			end
			if (cmd.new_slot) begin
				extent_q <= extent_q + CNT_W'(1);
			end
			if (cmd.new_slot || cmd.revive) begin
				live_q <= live_q + CNT_W'(1);
			end
			if (cmd.retire) begin
				live_q <= live_q - CNT_W'(1);
			end
			if (cmd.pop_free) begin
				depth_q <= depth_dec;
			end
			if (ret_we) begin
				rcount_q <= rcount_q + CNT_W'(1);
			end
			if (cmd.drain) begin
				depth_q  <= depth_q + CNT_W'(1);
				head_q   <= head_inc;
				rcount_q <= rcount_q - CNT_W'(1);
				rel_n_q  <= rel_n_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			idx_q   <= slot_index;
			hgen_q  <= handle_generation;
			frame_q <= frame;
		end
		if (cmd.pop_free) begin
			slot_q <= free_rdata;
		end
		if (cmd.emit) begin
			status_q <= cmd.status;
			unique case (cmd.kind)
				EMIT_NEW: begin
					res_idx_q <= extent_q[IDX_W-1:0];
					res_gen_q <= GEN_W'(1);
				end
				EMIT_REUSE: begin
					res_idx_q <= slot_q;
					res_gen_q <= ram_gen;
				end
				EMIT_RANGE: begin
					res_idx_q <= idx_q;
					res_gen_q <= '0;
				end
				EMIT_SLOT: begin
					res_idx_q <= idx_q;
					res_gen_q <= ram_gen;
				end
				EMIT_RETIRE: begin
					res_idx_q <= idx_q;
					res_gen_q <= gen_bump;
				end
				default: begin
					res_idx_q <= '0;
					res_gen_q <= '0;
				end
			endcase
		end
	end

	assign status            = status_q;
	assign result_index      = res_idx_q;
	assign result_generation = res_gen_q;
	assign live_count        = live_q;
	assign used_extent       = extent_q;
	assign released_count    = rel_n_q;

endmodule

`default_nettype wire

// ===== sv/generational_slot_allocator.sv =====
`default_nettype none
// Check and destroy give their result from S_CHECK or S_DESTROY, allocate from S_ALLOC
// for a never-used slot and from S_ALLOC_RD after a pop from the free stack, and release
// from S_RELEASE when it stops moving retired slots to the free stack. A new item is taken
// only once the last one is through; busy is high from the accept edge until the result.
// Reset clears all counters and pointers at once; no clearing pass, the block takes
// items in the first cycle after reset. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
// generational_slot_allocator: slot table with generation-tagged handles
// Hands out slot handles (index, generation), validates them, and retires
// destroyed slots for a programmable number of frames before reuse.
// ----------------------------------------------------------------------------
//
// Structure
//   The controller (gsa_ctrl) is a one-hot state machine that steps each item
//   through its memory accesses. The datapath (gsa_dp) holds three memories:
//     - the slot table, one word per slot with the live bit above the
//       generation,
//     - the free stack of released slot indexes,
//     - the retired queue of (slot, due frame) pairs, kept in retirement order.
//   Only the words of slots below the used extent are ever used, so the slot table
//   needs no clearing after reset: the extent acts as its fill count.
//
// Operations
//   Allocate pops the free stack if it holds an entry, otherwise takes the
//   next never-used slot at generation 1, otherwise reports a full table.
//   Destroy of a live slot clears its live bit, advances its generation
//   (skipping zero on wrap) and queues the slot until frame plus the reuse
//   delay, saturated at the largest frame number.
//   Release moves retired slots whose due frame has come onto the free
//   stack, one slot per cycle, and stops at the first one not yet due.
//   Check compares the handle with the live slot's generation.
//
// Configuration
//   cfg_we writes cfg_wdata into the reuse delay register (reset value 3).
// ----------------------------------------------------------------------------
module generational_slot_allocator #(
	parameter int SLOT_COUNT      = gsa_pkg::SLOT_COUNT_DEF,
	parameter int GENERATION_BITS = gsa_pkg::GEN_BITS_DEF,
	localparam int IDX_W = $clog2(SLOT_COUNT),
	localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gsa_pkg::DELAY_W-1:0]   cfg_wdata,
	input  wire logic                          start,
	input  wire logic [gsa_pkg::OPCODE_W-1:0]  opcode,
	input  wire logic [IDX_W-1:0]              slot_index,
	input  wire logic [GENERATION_BITS-1:0]    handle_generation,
	input  wire logic [gsa_pkg::FRAME_W-1:0]   frame,
	output logic                               busy,
	output logic                               done,
	output logic [gsa_pkg::STATUS_W-1:0]       status,
	output logic [IDX_W-1:0]                   result_index,
	output logic [GENERATION_BITS-1:0]         result_generation,
	output logic [CNT_W-1:0]                   live_count,
	output logic [CNT_W-1:0]                   used_extent,
	output logic [CNT_W-1:0]                   released_count
);

	import gsa_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	gsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gsa_dp #(
		.SLOT_COUNT      (SLOT_COUNT),
		.GENERATION_BITS (GENERATION_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.slot_index        (slot_index),
		.handle_generation (handle_generation),
		.frame             (frame),
		.cmd               (cmd),
		.stat              (stat),
		.status            (status),
		.result_index      (result_index),
		.result_generation (result_generation),
		.live_count        (live_count),
		.used_extent       (used_extent),
		.released_count    (released_count)
	);

endmodule

`default_nettype wire
